/* rtl/qmd_pkg.sv */
// shared types, mode codes and the constellation level scaling function for the qam demapper
// no dependencies
package qmd_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF    = 13;
    localparam int RX_FIELD_W       = 16;
    localparam int PIPE_DEPTH       = 4;

    typedef logic [1:0] t_mod;

    localparam t_mod MOD_QPSK  = 2'd0;
    localparam t_mod MOD_QAM16 = 2'd1;
    localparam t_mod MOD_QAM64 = 2'd2;
    localparam t_mod MOD_RSVD  = 2'd3;

    typedef struct packed {
        logic signed [RX_FIELD_W-1:0] rx_in_phase;
        logic signed [RX_FIELD_W-1:0] rx_quadrature;
    } t_rx_item;

    typedef struct packed {
        logic [5:0] sym_index;
        logic [2:0] bit_count;
    } t_sym_item;

    // per-axis decision: sign bit and amplitude code
    typedef struct packed {
        logic       sign;
        logic [1:0] code;
    } t_axis_dec;

    // round(level * 2^frac / sqrt(k)), evaluated at elaboration only
    function automatic longint unsigned scaled_level(input int unsigned level,
                                                     input int unsigned k,
                                                     input int unsigned frac);
        longint unsigned four_n;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        four_n = 64'd4 * level * level * (64'd1 << (2 * frac));
        lo     = 64'd0;
        hi     = 64'd1 << (frac + 3);
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            t   = 64'd2 * mid - 64'd1;
            if (k * t * t <= four_n) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return lo;
    endfunction

endpackage

/* rtl/qmd_axis_slicer.sv */
// four-stage nearest-level slicer for one axis: magnitude, difference, square, minimum
// depends on qmd_pkg
module qmd_axis_slicer #(
    parameter int SAMPLE_WIDTH = qmd_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = qmd_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  qmd_pkg::t_mod                  i_mode,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output qmd_pkg::t_axis_dec             o_dec
);
    import qmd_pkg::*;

    localparam int MW  = FRAC_BITS + 2;
    localparam int DW  = ((SAMPLE_WIDTH > MW) ? SAMPLE_WIDTH : MW) + 1;
    localparam int SQW = 2 * DW;

    localparam logic [MW-1:0] LV_Q_1   = MW'(scaled_level(1, 2, FRAC_BITS));
    localparam logic [MW-1:0] LV_16_1  = MW'(scaled_level(1, 10, FRAC_BITS));
    localparam logic [MW-1:0] LV_16_3  = MW'(scaled_level(3, 10, FRAC_BITS));
    localparam logic [MW-1:0] LV_64_1  = MW'(scaled_level(1, 42, FRAC_BITS));
    localparam logic [MW-1:0] LV_64_3  = MW'(scaled_level(3, 42, FRAC_BITS));
    localparam logic [MW-1:0] LV_64_5  = MW'(scaled_level(5, 42, FRAC_BITS));
    localparam logic [MW-1:0] LV_64_7  = MW'(scaled_level(7, 42, FRAC_BITS));

    logic                    r1_sign;
    logic [SAMPLE_WIDTH-1:0] r1_abs;
    t_mod                    r1_mode;
    logic [SAMPLE_WIDTH-1:0] n1_neg;

    logic                    r2_sign;
    logic [3:0]              r2_en;
    logic signed [DW-1:0]    r2_diff [4];
    logic [3:0]              n2_en;
    logic [MW-1:0]           n2_mag  [4];

    logic                    r3_sign;
    logic [3:0]              r3_en;
    logic [SQW-1:0]          r3_sq   [4];
    logic signed [SQW-1:0]   n3_prod [4];

    logic                    r4_sign;
    logic [1:0]              r4_code;
    logic [SQW-1:0]          n4_best;
    logic [1:0]              n4_code;

    // stage 1: sign and magnitude
    assign n1_neg = (~i_sample) + SAMPLE_WIDTH'(1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sign <= i_sample[SAMPLE_WIDTH-1];
            r1_abs  <= i_sample[SAMPLE_WIDTH-1] ? n1_neg
                                                 : i_sample[SAMPLE_WIDTH-1:0];
            r1_mode <= i_mode;
        end
    end

    // stage 2: level table per mode, distance to each level
    always_comb begin
        n2_mag[0] = LV_64_3;
        n2_mag[1] = LV_64_1;
        n2_mag[2] = LV_64_5;
        n2_mag[3] = LV_64_7;
        n2_en     = 4'b1111;
        unique case (r1_mode) inside
            MOD_QPSK: begin
                n2_mag[0] = LV_Q_1;
                n2_en     = 4'b0001;
            end
            MOD_QAM16: begin
                n2_mag[0] = LV_16_1;
                n2_mag[1] = LV_16_3;
                n2_en     = 4'b0011;
            end
            MOD_QAM64, MOD_RSVD: begin
                n2_en = 4'b1111;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_sign <= r1_sign;
            r2_en   <= n2_en;
            for (int j = 0; j < 4; j++) begin
                r2_diff[j] <= $signed({{(DW-SAMPLE_WIDTH){1'b0}}, r1_abs})
                            - $signed({{(DW-MW){1'b0}}, n2_mag[j]});
            end
        end
    end

    // stage 3: squares
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n3_prod[j] = SQW'(r2_diff[j]) * SQW'(r2_diff[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_sign <= r2_sign;
            r3_en   <= r2_en;
            for (int j = 0; j < 4; j++) begin
                r3_sq[j] <= unsigned'(n3_prod[j]);
            end
        end
    end

    // stage 4: minimum, lowest code on ties
    always_comb begin
        n4_best = r3_sq[0];
        n4_code = 2'd0;
        for (int j = 1; j < 4; j++) begin
            if (r3_en[j] && (r3_sq[j] < n4_best)) begin
                n4_best = r3_sq[j];
                n4_code = 2'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_sign <= r3_sign;
            r4_code <= n4_code;
        end
    end

    assign o_dec.sign = r4_sign;
    assign o_dec.code = r4_code;

endmodule

/* rtl/qam_min_distance_demapper_unit.sv */
// top level of the qam hard-decision demapper: handshake, mode register, output packing
// depends on qmd_pkg and qmd_axis_slicer
//
// Takes one I/Q sample per clock unless the output is stalled, and returns the index of
// the nearest QPSK, 16-QAM or 64-QAM point (LTE interleaved mapping, lowest index on
// equal distance) with its bit count. Each sample passes through the register pipeline
// (magnitude, level difference, square, minimum search), one per axis in parallel. A
// stall on the output freezes the whole pipeline. mod_order is written through the config
// transfer channel, which is always ready; code 3 decodes as 64-QAM.
module qam_min_distance_demapper_unit #(
    parameter int SAMPLE_WIDTH = qmd_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = qmd_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  qmd_pkg::t_rx_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output qmd_pkg::t_sym_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  qmd_pkg::t_mod      i_cfg_data
);
    import qmd_pkg::*;

    logic                           w_adv;
    logic signed [SAMPLE_WIDTH-1:0] w_i;
    logic signed [SAMPLE_WIDTH-1:0] w_q;
    t_axis_dec                      w_dec_i;
    t_axis_dec                      w_dec_q;

    t_mod                           r_mod_order;
    logic [PIPE_DEPTH-1:0]          r_vld;
    t_mod                           r_mode_pipe [PIPE_DEPTH];

    assign w_adv       = !(r_vld[PIPE_DEPTH-1] && i_out_stall);
    assign o_in_stall  = !w_adv;
    assign o_out_valid = r_vld[PIPE_DEPTH-1];
    assign o_cfg_ready = 1'b1;

    generate
        if (SAMPLE_WIDTH <= RX_FIELD_W) begin : g_trunc
            assign w_i = i_in_data.rx_in_phase[SAMPLE_WIDTH-1:0];
            assign w_q = i_in_data.rx_quadrature[SAMPLE_WIDTH-1:0];
        end else begin : g_sext
            assign w_i = {{(SAMPLE_WIDTH-RX_FIELD_W){i_in_data.rx_in_phase[RX_FIELD_W-1]}},
                          i_in_data.rx_in_phase};
            assign w_q = {{(SAMPLE_WIDTH-RX_FIELD_W){i_in_data.rx_quadrature[RX_FIELD_W-1]}},
                          i_in_data.rx_quadrature};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_order <= MOD_QPSK;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mod_order <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mode_pipe[0] <= r_mod_order;
            for (int s = 1; s < PIPE_DEPTH; s++) begin
                r_mode_pipe[s] <= r_mode_pipe[s-1];
            end
        end
    end

    qmd_axis_slicer #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_slicer_i (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_mode   (r_mod_order),
        .i_sample (w_i),
        .o_dec    (w_dec_i)
    );

    qmd_axis_slicer #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_slicer_q (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_mode   (r_mod_order),
        .i_sample (w_q),
        .o_dec    (w_dec_q)
    );

    // interleave i and q bits, msb first
    always_comb begin
        unique case (r_mode_pipe[PIPE_DEPTH-1]) inside
            MOD_QPSK: begin
                o_out_data.sym_index = {4'b0000, w_dec_i.sign, w_dec_q.sign};
                o_out_data.bit_count = 3'd2;
            end
            MOD_QAM16: begin
                o_out_data.sym_index = {2'b00, w_dec_i.sign, w_dec_q.sign,
                                        w_dec_i.code[0], w_dec_q.code[0]};
                o_out_data.bit_count = 3'd4;
            end
            MOD_QAM64, MOD_RSVD: begin
                o_out_data.sym_index = {w_dec_i.sign, w_dec_q.sign,
                                        w_dec_i.code[1], w_dec_q.code[1],
                                        w_dec_i.code[0], w_dec_q.code[0]};
                o_out_data.bit_count = 3'd6;
            end
        endcase
    end

endmodule
